@@ rtl/core/ctfc_pkg.sv @@
// Shared constants, types and tables for the cubic texture family counter.
`timescale 1ns / 1ps
package ctfc_pkg;

  localparam int COUNT_WIDTH  = 24;
  localparam int OUT_WIDTH    = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int ADDR_WIDTH   = 4;

  localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;
  localparam logic signed [17:0] INV_ROOT2_Q16 = 18'sd46341;
  localparam logic signed [17:0] INV_ROOT3_Q16 = 18'sd37837;
  localparam logic [15:0]        ONE_Q15       = 16'd32768;
  localparam logic [15:0]        RATIO_MAX     = 16'd65535;

  localparam logic [1:0] REG_DIR_X  = 2'd0;
  localparam logic [1:0] REG_DIR_Y  = 2'd1;
  localparam logic [1:0] REG_DIR_Z  = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;

  typedef logic signed [17:0] trig_t;
  typedef logic signed [33:0] cordic_t;
  typedef logic signed [35:0] vec_t;
  typedef logic [COUNT_WIDTH-1:0] tally_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CORDIC = 6'b000010,
    ST_CALC   = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  function automatic cordic_t atan_val(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return cordic_t'({4'b0000, v});
  endfunction

endpackage

@@ rtl/core/cubic_texture_family_counter.sv @@
// Top level: pole family classifier with per-family tallies and set summary.
`timescale 1ns / 1ps
// Each request takes one Euler triple. A shared CORDIC rotator produces the
// sine and cosine of the three angles one after the other, then one shared
// multiplier builds the orientation matrix, rotates the sample direction and
// scales the family maxima, and the decide state updates the tallies; in_ready
// stays low until the point is done. A request flagged as the last point adds
// three restoring divisions for the ratios before the summary is loaded into
// the output register; it waits there until taken, and the tallies restart
// from zero for the next set.
module cubic_texture_family_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] phi_one,
  input  logic [15:0] big_phi,
  input  logic [15:0] phi_two,
  input  logic        last_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [ctfc_pkg::OUT_WIDTH-1:0] count_001,
  output logic [ctfc_pkg::OUT_WIDTH-1:0] count_110,
  output logic [ctfc_pkg::OUT_WIDTH-1:0] count_111,
  output logic [ctfc_pkg::OUT_WIDTH-1:0] total_points,
  output logic [15:0] ratio_001,
  output logic [15:0] ratio_110,
  output logic [15:0] ratio_111,
  output logic        none_accepted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ctfc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ctfc_pkg::*;

  state_t state;

  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [15:0]        cos_threshold;

  logic [15:0] ang_a, ang_b, ang_c;
  logic        last;

  cordic_t    cx, cy, cz;
  cordic_t    cx_next, cy_next, cz_next;
  trig_t      xr, yr, cos_v, sin_v;
  logic [4:0] iter;
  logic [1:0] asel;
  logic [15:0] ang;

  trig_t c1, s1, cp, sp, c2, s2;
  trig_t g0, g1, g2, g3, g4, g5, g6, g7, g8;

  logic [5:0] step;
  logic [3:0] k;
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] prod;
  logic signed [35:0] tmp;
  logic signed [47:0] acc;
  vec_t px, py, pz, cand, cand_abs, mx;
  logic [15:0] d001, d110, d111;

  tally_t tally_001, tally_110, tally_111, point_tally;

  logic [15:0] best;
  logic [1:0]  fam;

  logic [1:0]        rsel;
  logic [4:0]        dcnt;
  logic [COUNT_WIDTH:0] rem, rem2;
  logic [15:0]       quo;
  logic              sat;
  tally_t            dnum;
  logic [15:0]       quo_next;
  logic [15:0]       r001, r110, r111;

  logic out_load;

  function automatic trig_t rnd28(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd134217728;
    return trig_t'(t >>> 28);
  endfunction

  function automatic trig_t rnd14(input logic signed [53:0] v);
    logic signed [53:0] t;
    t = v + 54'sd8192;
    return trig_t'(t >>> 14);
  endfunction

  function automatic logic [15:0] clamp_q15(input logic [24:0] v);
    return (v > 25'(ONE_Q15)) ? ONE_Q15 : v[15:0];
  endfunction

  function automatic tally_t sat_inc(input tally_t v);
    return (v == '1) ? v : v + tally_t'(1);
  endfunction

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_DIR_X:  prdata = 32'(dir_x);
      REG_DIR_Y:  prdata = 32'(dir_y);
      REG_DIR_Z:  prdata = 32'(dir_z);
      REG_THRESH: prdata = {16'd0, cos_threshold};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_x         <= 16'sd0;
      dir_y         <= 16'sd0;
      dir_z         <= 16'sd16384;
      cos_threshold <= 16'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_DIR_X:  dir_x         <= pwdata[15:0];
        REG_DIR_Y:  dir_y         <= pwdata[15:0];
        REG_DIR_Z:  dir_z         <= pwdata[15:0];
        REG_THRESH: cos_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  // CORDIC rotator
  always_comb begin
    unique case (asel)
      SEL_A:   ang = ang_a;
      SEL_B:   ang = ang_b;
      default: ang = ang_c;
    endcase
    if (cz >= 0) begin
      cx_next = cx - (cy >>> iter);
      cy_next = cy + (cx >>> iter);
      cz_next = cz - atan_val(iter);
    end else begin
      cx_next = cx + (cy >>> iter);
      cy_next = cy - (cx >>> iter);
      cz_next = cz + atan_val(iter);
    end
    xr = trig_t'((cx_next + 34'sd32768) >>> 16);
    yr = trig_t'((cy_next + 34'sd32768) >>> 16);
    unique case (ang[15:14])
      2'd0: begin
        cos_v = xr;
        sin_v = yr;
      end
      2'd1: begin
        cos_v = -yr;
        sin_v = xr;
      end
      2'd2: begin
        cos_v = -xr;
        sin_v = -yr;
      end
      default: begin
        cos_v = yr;
        sin_v = -xr;
      end
    endcase
  end

  // multiplier operand schedule
  always_comb begin
    mul_a = 36'sd0;
    mul_b = 18'sd0;
    unique case (step)
      6'd0:  begin mul_a = 36'(s1);  mul_b = s2; end
      6'd1:  begin mul_a = 36'(c1);  mul_b = c2; end
      6'd2:  begin mul_a = tmp;      mul_b = cp; end
      6'd3:  begin mul_a = 36'(c1);  mul_b = s2; end
      6'd4:  begin mul_a = 36'(s1);  mul_b = c2; end
      6'd5:  begin mul_a = tmp;      mul_b = cp; end
      6'd6:  begin mul_a = 36'(s1);  mul_b = c2; end
      6'd7:  begin mul_a = 36'(c1);  mul_b = s2; end
      6'd8:  begin mul_a = tmp;      mul_b = cp; end
      6'd9:  begin mul_a = 36'(s1);  mul_b = s2; end
      6'd10: begin mul_a = 36'(c1);  mul_b = c2; end
      6'd12: begin mul_a = tmp;      mul_b = cp; end
      6'd13: begin mul_a = 36'(s2);  mul_b = sp; end
      6'd14: begin mul_a = 36'(c2);  mul_b = sp; end
      6'd15: begin mul_a = 36'(s1);  mul_b = sp; end
      6'd16: begin mul_a = 36'(c1);  mul_b = sp; end
      6'd17: begin mul_a = 36'(g0);  mul_b = 18'(dir_x); end
      6'd18: begin mul_a = 36'(g1);  mul_b = 18'(dir_y); end
      6'd19: begin mul_a = 36'(g2);  mul_b = 18'(dir_z); end
      6'd20: begin mul_a = 36'(g3);  mul_b = 18'(dir_x); end
      6'd21: begin mul_a = 36'(g4);  mul_b = 18'(dir_y); end
      6'd22: begin mul_a = 36'(g5);  mul_b = 18'(dir_z); end
      6'd23: begin mul_a = 36'(g6);  mul_b = 18'(dir_x); end
      6'd24: begin mul_a = 36'(g7);  mul_b = 18'(dir_y); end
      6'd25: begin mul_a = 36'(g8);  mul_b = 18'(dir_z); end
      6'd36: begin mul_a = mx;       mul_b = INV_ROOT2_Q16; end
      6'd40: begin mul_a = mx;       mul_b = INV_ROOT3_Q16; end
      default: ;
    endcase
  end

  // family candidates, one per cycle
  always_comb begin
    k = 4'(step - 6'd27);
    unique case (k)
      4'd0:  cand = px;
      4'd1:  cand = py;
      4'd2:  cand = pz;
      4'd3:  cand = px + py;
      4'd4:  cand = px + pz;
      4'd5:  cand = py + pz;
      4'd6:  cand = px - py;
      4'd7:  cand = px - pz;
      4'd8:  cand = py - pz;
      4'd9:  cand = px + py + pz;
      4'd10: cand = py + pz - px;
      4'd11: cand = px - py + pz;
      4'd12: cand = px + py - pz;
      default: cand = '0;
    endcase
    cand_abs = (cand < 0) ? -cand : cand;
  end

  always_comb begin
    best = d001;
    fam  = SEL_A;
    if (d110 > best) begin
      best = d110;
      fam  = SEL_B;
    end
    if (d111 > best) begin
      best = d111;
      fam  = SEL_C;
    end
  end

  // ratio divider
  always_comb begin
    unique case (rsel)
      SEL_A:   dnum = tally_001;
      SEL_B:   dnum = tally_110;
      default: dnum = tally_111;
    endcase
    rem2 = {rem[COUNT_WIDTH-1:0], 1'b0};
    if (rem2 >= {1'b0, point_tally}) begin
      quo_next = {quo[14:0], 1'b1};
    end else begin
      quo_next = {quo[14:0], 1'b0};
    end
  end

  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      tally_001   <= '0;
      tally_110   <= '0;
      tally_111   <= '0;
      point_tally <= '0;
      iter        <= 5'd0;
      asel        <= SEL_A;
      step        <= 6'd0;
      rsel        <= SEL_A;
      dcnt        <= 5'd0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ang_a <= phi_one;
            ang_b <= big_phi;
            ang_c <= phi_two;
            last  <= last_point;
            cx    <= CORDIC_GAIN;
            cy    <= '0;
            cz    <= cordic_t'({phi_one[13:0], 16'd0});
            iter  <= 5'd0;
            asel  <= SEL_A;
            state <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (iter == 5'(CORDIC_STEPS - 1)) begin
            iter <= 5'd0;
            cx   <= CORDIC_GAIN;
            cy   <= '0;
            unique case (asel)
              SEL_A: begin
                c1   <= cos_v;
                s1   <= sin_v;
                cz   <= cordic_t'({ang_b[13:0], 16'd0});
                asel <= SEL_B;
              end
              SEL_B: begin
                cp   <= cos_v;
                sp   <= sin_v;
                cz   <= cordic_t'({ang_c[13:0], 16'd0});
                asel <= SEL_C;
              end
              default: begin
                c2    <= cos_v;
                s2    <= sin_v;
                step  <= 6'd0;
                state <= ST_CALC;
              end
            endcase
          end else begin
            cx   <= cx_next;
            cy   <= cy_next;
            cz   <= cz_next;
            iter <= iter + 5'd1;
          end
        end
        ST_CALC: begin
          step <= step + 6'd1;
          unique case (step)
            6'd1:  tmp <= 36'(prod);
            6'd2:  acc <= 48'(prod <<< 14);
            6'd3:  g0  <= rnd28(acc - 48'(prod));
            6'd4:  tmp <= 36'(prod);
            6'd5:  acc <= 48'(prod <<< 14);
            6'd6:  g1  <= rnd28(acc + 48'(prod));
            6'd7:  tmp <= 36'(prod);
            6'd8:  acc <= -48'(prod <<< 14);
            6'd9:  g3  <= rnd28(acc - 48'(prod));
            6'd10: acc <= -48'(prod <<< 14);
            6'd11: tmp <= 36'(prod);
            6'd13: g4  <= rnd28(acc + 48'(prod));
            6'd14: g2  <= rnd14(prod);
            6'd15: g5  <= rnd14(prod);
            6'd16: g6  <= rnd14(prod);
            6'd17: begin
              g7 <= rnd14(-prod);
              g8 <= cp;
            end
            6'd18, 6'd21, 6'd24: acc <= 48'(prod);
            6'd19, 6'd22, 6'd25: acc <= acc + 48'(prod);
            6'd20: px <= vec_t'(acc + 48'(prod));
            6'd23: py <= vec_t'(acc + 48'(prod));
            6'd26: pz <= vec_t'(acc + 48'(prod));
            6'd37: d110 <= clamp_q15(prod[53:29]);
            6'd41: begin
              d111  <= clamp_q15(prod[53:29]);
              state <= ST_DECIDE;
            end
            default: ;
          endcase
          if (step >= 6'd27 && step <= 6'd39) begin
            if (k == 4'd0 || k == 4'd3 || k == 4'd9) begin
              mx <= cand_abs;
            end else if (cand_abs > mx) begin
              mx <= cand_abs;
            end
            if (k == 4'd3) begin
              d001 <= clamp_q15(25'(mx[35:13]));
            end
          end
        end
        ST_DECIDE: begin
          point_tally <= sat_inc(point_tally);
          if (best >= cos_threshold) begin
            unique case (fam)
              SEL_A:   tally_001 <= sat_inc(tally_001);
              SEL_B:   tally_110 <= sat_inc(tally_110);
              default: tally_111 <= sat_inc(tally_111);
            endcase
          end
          rsel  <= SEL_A;
          dcnt  <= 5'd0;
          state <= last ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (dcnt == 5'd0) begin
            sat  <= (dnum >= point_tally);
            rem  <= (dnum >= point_tally) ? {1'b0, dnum - point_tally} : {1'b0, dnum};
            quo  <= 16'd0;
            dcnt <= 5'd1;
          end else begin
            rem <= (rem2 >= {1'b0, point_tally}) ? rem2 - {1'b0, point_tally} : rem2;
            quo <= quo_next;
            if (dcnt == 5'd16) begin
              dcnt <= 5'd0;
              unique case (rsel)
                SEL_A:   r001 <= sat ? RATIO_MAX : quo_next;
                SEL_B:   r110 <= sat ? RATIO_MAX : quo_next;
                default: r111 <= sat ? RATIO_MAX : quo_next;
              endcase
              if (rsel == SEL_C) begin
                state <= ST_DONE;
              end else begin
                rsel <= rsel + 2'd1;
              end
            end else begin
              dcnt <= dcnt + 5'd1;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            count_001     <= OUT_WIDTH'(tally_001);
            count_110     <= OUT_WIDTH'(tally_110);
            count_111     <= OUT_WIDTH'(tally_111);
            total_points  <= OUT_WIDTH'(point_tally);
            ratio_001     <= r001;
            ratio_110     <= r110;
            ratio_111     <= r111;
            none_accepted <= ((tally_001 | tally_110 | tally_111) == '0);
            tally_001     <= '0;
            tally_110     <= '0;
            tally_111     <= '0;
            point_tally   <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ test/tb_cubic_texture_family_counter.sv @@
// Testbench for the cubic texture family counter: pole family tallies and set summaries.
`timescale 1ns / 1ps
module tb_cubic_texture_family_counter;
  import ctfc_pkg::*;

  typedef struct {
    logic [23:0] c001;
    logic [23:0] c110;
    logic [23:0] c111;
    logic [23:0] total;
    logic [15:0] r001;
    logic [15:0] r110;
    logic [15:0] r111;
    logic        none;
  } summary_t;

  localparam longint ATAN[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] phi_one = '0;
  logic [15:0] big_phi = '0;
  logic [15:0] phi_two = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_WIDTH-1:0] count_001, count_110, count_111, total_points;
  logic [15:0] ratio_001, ratio_110, ratio_111;
  logic none_accepted;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  longint sample_x, sample_y, sample_z, accept_cos;
  longint fam_tally[3];
  longint set_tally;
  summary_t summaries_due[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  cubic_texture_family_counter u_dut (.*);

  always #5 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void angle_trig(input logic [15:0] ang, output longint c,
                                     output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(ang[13:0]) <<< 16;
    for (int i = 0; i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    x = round_shift(x, 16);
    y = round_shift(y, 16);
    case (ang[15:14])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint bump(longint v);
    return v < 64'hFFFFFF ? v + 1 : v;
  endfunction

  function automatic logic [15:0] ratio_of(longint cnt, longint tot);
    longint r;
    if (tot == 0) return 16'd0;
    r = (cnt <<< 16) / tot;
    return r > 65535 ? 16'd65535 : 16'(r);
  endfunction

  task automatic classify_point(input logic [15:0] a1, a2, a3, input logic fin);
    longint c1, s1, cp, sp, c2, s2, px, py, pz, m, d0, d1, d2, best;
    longint g[9];
    int fam;
    summary_t sm;
    angle_trig(a1, c1, s1);
    angle_trig(a2, cp, sp);
    angle_trig(a3, c2, s2);
    g[0] = round_shift(c1 * c2 * 16384 - s1 * s2 * cp, 28);
    g[1] = round_shift(s1 * c2 * 16384 + c1 * s2 * cp, 28);
    g[2] = round_shift(s2 * sp, 14);
    g[3] = round_shift(-c1 * s2 * 16384 - s1 * c2 * cp, 28);
    g[4] = round_shift(-s1 * s2 * 16384 + c1 * c2 * cp, 28);
    g[5] = round_shift(c2 * sp, 14);
    g[6] = round_shift(s1 * sp, 14);
    g[7] = round_shift(-c1 * sp, 14);
    g[8] = cp;
    px = g[0] * sample_x + g[1] * sample_y + g[2] * sample_z;
    py = g[3] * sample_x + g[4] * sample_y + g[5] * sample_z;
    pz = g[6] * sample_x + g[7] * sample_y + g[8] * sample_z;
    m = mag(px);
    if (mag(py) > m) m = mag(py);
    if (mag(pz) > m) m = mag(pz);
    d0 = m >>> 13;
    m = 0;
    for (int k = 0; k < 6; k++) begin
      longint v;
      case (k)
        0: v = px + py; 1: v = px + pz; 2: v = py + pz;
        3: v = px - py; 4: v = px - pz; default: v = py - pz;
      endcase
      if (mag(v) > m) m = mag(v);
    end
    d1 = (m * 46341) >>> 29;
    m = 0;
    for (int k = 0; k < 4; k++) begin
      longint v;
      case (k)
        0: v = px + py + pz; 1: v = -px + py + pz;
        2: v = px - py + pz; default: v = px + py - pz;
      endcase
      if (mag(v) > m) m = mag(v);
    end
    d2 = (m * 37837) >>> 29;
    if (d0 > 32768) d0 = 32768;
    if (d1 > 32768) d1 = 32768;
    if (d2 > 32768) d2 = 32768;
    best = d0; fam = 0;
    if (d1 > best) begin best = d1; fam = 1; end
    if (d2 > best) begin best = d2; fam = 2; end
    set_tally = bump(set_tally);
    if (best >= accept_cos) fam_tally[fam] = bump(fam_tally[fam]);
    if (fin) begin
      sm.c001 = fam_tally[0][23:0];
      sm.c110 = fam_tally[1][23:0];
      sm.c111 = fam_tally[2][23:0];
      sm.total = set_tally[23:0];
      sm.r001 = ratio_of(fam_tally[0], set_tally);
      sm.r110 = ratio_of(fam_tally[1], set_tally);
      sm.r111 = ratio_of(fam_tally[2], set_tally);
      sm.none = (fam_tally[0] | fam_tally[1] | fam_tally[2]) == 0;
      summaries_due.push_back(sm);
      fam_tally = '{0, 0, 0};
      set_tally = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_WIDTH'({idx, 2'b00}); pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DIR_X: sample_x = longint'($signed(val));
      REG_DIR_Y: sample_y = longint'($signed(val));
      REG_DIR_Z: sample_z = longint'($signed(val));
      default: accept_cos = longint'(val);
    endcase
  endtask

  task automatic set_direction(input int x, y, z, input int thr);
    write_reg(REG_DIR_X, 16'(x));
    write_reg(REG_DIR_Y, 16'(y));
    write_reg(REG_DIR_Z, 16'(z));
    write_reg(REG_THRESH, 16'(thr));
  endtask

  task automatic send_point(input logic [15:0] a1, a2, a3, input logic fin);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    phi_one <= a1; big_phi <= a2; phi_two <= a3; last_point <= fin;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    classify_point(a1, a2, a3, fin);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (summaries_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_set(input int n);
    for (int i = 0; i < n; i++)
      send_point($urandom, $urandom, $urandom, i == n - 1);
  endtask

  task automatic test_directed;
    logic [15:0] ext[6] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h2000};
    foreach (ext[i]) send_point(ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6], 1'b0);
    send_point(16'h0000, 16'h0000, 16'h0000, 1'b1);
    drain();
    set_direction(16384, 0, 0, 32768);
    send_point(16'h1234, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0000, 16'h0000, 1'b1);
    drain();
    set_direction(0, 0, 0, 0);
    send_point(16'h5555, 16'hAAAA, 16'h1111, 1'b1);
    drain();
    set_direction(0, 0, 0, 1);
    send_point(16'h5555, 16'hAAAA, 16'h1111, 1'b1);
    drain();
    set_direction(11585, 11585, 0, 65535);
    send_point(16'h2000, 16'h4000, 16'h6000, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    drain();
    set_direction(-16384, 16384, -16384, 30000);
    send_point(16'h2000, 16'h2000, 16'h2000, 1'b1);
    drain();
  endtask

  task automatic test_random_sets;
    int thr[5] = '{0, 32768, 28000, 31000, 20000};
    for (int p = 0; p < 5; p++) begin
      set_direction($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                    $urandom_range(0, 32768) - 16384, thr[p]);
      for (int k = 0; k < 52; k++) random_set($urandom_range(1, 8));
      drain();
    end
  endtask

  task automatic test_steady_stream;
    calm = 1'b1;
    set_direction(9459, 9459, 9459, 30000);
    for (int k = 0; k < 40; k++) random_set($urandom_range(1, 5));
    drain();
  endtask

  initial begin
    summary_t want;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (summaries_due.size() == 0) begin
          $display("unexpected summary at %0t", $realtime);
          error_count++;
        end else begin
          want = summaries_due.pop_front();
          if (count_001 !== want.c001) report_mismatch("count_001", count_001, want.c001);
          if (count_110 !== want.c110) report_mismatch("count_110", count_110, want.c110);
          if (count_111 !== want.c111) report_mismatch("count_111", count_111, want.c111);
          if (total_points !== want.total)
            report_mismatch("total_points", total_points, want.total);
          if (ratio_001 !== want.r001) report_mismatch("ratio_001", ratio_001, want.r001);
          if (ratio_110 !== want.r110) report_mismatch("ratio_110", ratio_110, want.r110);
          if (ratio_111 !== want.r111) report_mismatch("ratio_111", ratio_111, want.r111);
          if (none_accepted !== want.none)
            report_mismatch("none_accepted", none_accepted, want.none);
        end
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (calm) out_ready <= 1'b1;
      else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 18);
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    sample_x = 0; sample_y = 0; sample_z = 16384; accept_cos = 0;
    fam_tally = '{0, 0, 0};
    set_tally = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_sets();
    test_steady_stream();
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ cubic_texture_family_counter.f @@
rtl/core/ctfc_pkg.sv
rtl/core/cubic_texture_family_counter.sv
test/tb_cubic_texture_family_counter.sv
